// ===== rtl/s256_pkg.sv =====
package s256_pkg;

    localparam int unsigned LANES = 4;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef logic [31:0] word_t;

    // Controller to datapath
    typedef struct packed {
        logic       push;       // shift one word into every lane's schedule
        logic       use_input;  // word = (lane word & keep) | fill, else fill
        word_t      keep;
        word_t      fill;
        logic       init;       // working variables <= chain value
        logic       round;      // one compression round
        logic [5:0] rnd;
        logic       fold;       // chain value += working variables
        logic       rearm;      // chain value <= initial values
        logic [2:0] out_sel;
    } s256_cmd_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/s256_if.sv =====
interface s256_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] lane0_word;
    logic [31:0] lane1_word;
    logic [31:0] lane2_word;
    logic [31:0] lane3_word;
    logic [2:0]  valid_bytes;
    logic        message_end;

    modport source (
        output valid, lane0_word, lane1_word, lane2_word, lane3_word,
               valid_bytes, message_end,
        input  ready
    );
    modport sink (
        input  valid, lane0_word, lane1_word, lane2_word, lane3_word,
               valid_bytes, message_end,
        output ready
    );
endinterface

interface s256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_lane0;
    logic [31:0] digest_lane1;
    logic [31:0] digest_lane2;
    logic [31:0] digest_lane3;
    logic [2:0]  word_number;
    logic        digest_done;

    modport source (
        output valid, digest_lane0, digest_lane1, digest_lane2, digest_lane3,
               word_number, digest_done,
        input  ready
    );
    modport sink (
        input  valid, digest_lane0, digest_lane1, digest_lane2, digest_lane3,
               word_number, digest_done,
        output ready
    );
endinterface

// ===== rtl/s256_ctrl.sv =====
module s256_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        valid_bytes,
    input  logic              message_end,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        word_number,
    output logic              digest_done,
    output s256_pkg::s256_cmd_t cmd
);
    import s256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN_LO,
        PH_DONE
    } phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [3:0]  count_reg;
    logic [30:0] total_reg;
    logic [5:0]  rnd_reg;
    logic        finishing_reg;
    logic [2:0]  out_idx_reg;

    logic        in_fire;
    logic        block_full;
    logic [2:0]  nv;
    logic [3:0]  count_next;
    word_t       len_hi;
    word_t       len_lo;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign word_number = out_idx_reg;
    assign digest_done = (out_idx_reg == 3'd7);

    assign in_fire    = in_ready && in_valid;
    assign block_full = (count_reg == 4'd15);
    assign count_next = block_full ? 4'd0 : count_reg + 4'd1;
    // counts of five to seven act as four
    assign nv         = valid_bytes[2] ? 3'd4 : {1'b0, valid_bytes[1:0]};
    assign len_hi     = {30'd0, total_reg[30:29]};
    assign len_lo     = {total_reg[28:0], 3'd0};

    always_comb
    begin
        cmd           = '0;
        cmd.rnd       = rnd_reg;
        cmd.out_sel   = out_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.push      = in_fire;
                cmd.use_input = 1'b1;
                cmd.keep      = 32'hffff_ffff;
                cmd.fill      = 32'd0;
                if (message_end && !valid_bytes[2])
                begin
                    unique case (valid_bytes[1:0])
                        2'd0:
                        begin
                            cmd.keep = 32'h0000_0000;
                            cmd.fill = 32'h8000_0000;
                        end
                        2'd1:
                        begin
                            cmd.keep = 32'hff00_0000;
                            cmd.fill = 32'h0080_0000;
                        end
                        2'd2:
                        begin
                            cmd.keep = 32'hffff_0000;
                            cmd.fill = 32'h0000_8000;
                        end
                        default:
                        begin
                            cmd.keep = 32'hffff_ff00;
                            cmd.fill = 32'h0000_0080;
                        end
                    endcase
                end
                cmd.init = in_fire && block_full;
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                unique case (phase_reg)
                    PH_MARK:   cmd.fill = PAD_MARK;
                    PH_ZERO:   cmd.fill = (count_reg == 4'd14) ? len_hi : 32'd0;
                    PH_LEN_LO: cmd.fill = len_lo;
                    default:   cmd.fill = 32'd0;
                endcase
                cmd.init = block_full;
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_FOLD:  cmd.fold  = 1'b1;
            ST_OUT:   cmd.rearm = out_ready && (out_idx_reg == 3'd7);
            default:  cmd.push  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DONE;
            count_reg     <= 4'd0;
            total_reg     <= 31'd0;
            rnd_reg       <= 6'd0;
            finishing_reg <= 1'b0;
            out_idx_reg   <= 3'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        count_reg <= count_next;
                        total_reg <= total_reg + (message_end ? 31'(nv) : 31'd4);
                        if (message_end)
                        begin
                            finishing_reg <= 1'b1;
                            phase_reg     <= valid_bytes[2] ? PH_MARK : PH_ZERO;
                        end
                        rnd_reg <= 6'd0;
                        if (block_full)
                            state_reg <= ST_ROUND;
                        else if (message_end)
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    count_reg <= count_next;
                    unique case (phase_reg)
                        PH_MARK:   phase_reg <= PH_ZERO;
                        PH_ZERO:
                        begin
                            if (count_reg == 4'd14)
                                phase_reg <= PH_LEN_LO;
                        end
                        PH_LEN_LO: phase_reg <= PH_DONE;
                        default:   phase_reg <= PH_DONE;
                    endcase
                    rnd_reg <= 6'd0;
                    if (block_full)
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    out_idx_reg <= 3'd0;
                    if (!finishing_reg)
                        state_reg <= ST_IDLE;
                    else if (phase_reg == PH_DONE)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_PAD;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            state_reg     <= ST_IDLE;
                            count_reg     <= 4'd0;
                            total_reg     <= 31'd0;
                            finishing_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/s256_lane.sv =====
module s256_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  s256_pkg::s256_cmd_t cmd,
    input  logic [31:0]         in_word,
    input  logic [31:0]         k_word,
    output logic [31:0]         digest
);
    import s256_pkg::*;

    word_t sched_reg [BLOCK_WORDS];
    word_t v_reg     [DIGEST_WORDS];
    word_t h_reg     [DIGEST_WORDS];

    word_t w_new;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t mj;
    word_t s0;
    word_t s1;
    word_t bs0;
    word_t bs1;

    // sched_reg[0] holds w[t]; the tail receives w[t+16]
    assign s0    = rotr(sched_reg[1], 7) ^ rotr(sched_reg[1], 18) ^ (sched_reg[1] >> 3);
    assign s1    = rotr(sched_reg[14], 17) ^ rotr(sched_reg[14], 19)
                   ^ (sched_reg[14] >> 10);
    assign w_new = s1 + sched_reg[9] + s0 + sched_reg[0];

    assign bs1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign bs0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + bs1 + ch + k_word + sched_reg[0];
    assign t2  = bs0 + mj;

    assign digest = h_reg[cmd.out_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[BLOCK_WORDS - 1] <= cmd.push ? in_word : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                h_reg[i] <= INIT_H[i];
        end
        else if (cmd.rearm)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                h_reg[i] <= INIT_H[i];
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

endmodule

// ===== rtl/s256_datapath.sv =====
module s256_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  s256_pkg::s256_cmd_t cmd,
    input  logic [31:0]         lane0_word,
    input  logic [31:0]         lane1_word,
    input  logic [31:0]         lane2_word,
    input  logic [31:0]         lane3_word,
    output logic [31:0]         digest_lane0,
    output logic [31:0]         digest_lane1,
    output logic [31:0]         digest_lane2,
    output logic [31:0]         digest_lane3
);
    import s256_pkg::*;

    word_t src   [LANES];
    word_t push  [LANES];
    word_t dig   [LANES];
    word_t k_word;

    assign src[0] = lane0_word;
    assign src[1] = lane1_word;
    assign src[2] = lane2_word;
    assign src[3] = lane3_word;

    assign k_word = ROUND_K[cmd.rnd];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        assign push[g] = cmd.use_input ? ((src[g] & cmd.keep) | cmd.fill) : cmd.fill;

        s256_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .in_word (push[g]),
            .k_word  (k_word),
            .digest  (dig[g])
        );
    end

    assign digest_lane0 = dig[0];
    assign digest_lane1 = dig[1];
    assign digest_lane2 = dig[2];
    assign digest_lane3 = dig[3];

endmodule

// ===== rtl/sha256_four_lane.sv =====
// Channel  Dir  Fields
// message  in   lane0_word..lane3_word, valid_bytes, message_end
// digest   out  digest_lane0..digest_lane3, word_number, digest_done
//
// Every 16th word starts a compression of the block: 64 rounds on one round unit
// per lane, then a fold of the chain value.
// A final transaction adds the padding words, one or two compressions
// and eight digest transactions.
// rst_n is asynchronous; the chain value resets to the initial hash values.
// message.ready is low while a block is compressed and from the end of a message
// until word 7 of the digest is taken; digest words hold while digest.ready is low.
module sha256_four_lane (
    input  logic          clk,
    input  logic          rst_n,
    s256_msg_if.sink      message,
    s256_digest_if.source digest
);
    import s256_pkg::*;

    s256_cmd_t cmd;

    s256_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (message.valid),
        .valid_bytes (message.valid_bytes),
        .message_end (message.message_end),
        .in_ready    (message.ready),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .word_number (digest.word_number),
        .digest_done (digest.digest_done),
        .cmd         (cmd)
    );

    s256_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .lane0_word   (message.lane0_word),
        .lane1_word   (message.lane1_word),
        .lane2_word   (message.lane2_word),
        .lane3_word   (message.lane3_word),
        .digest_lane0 (digest.digest_lane0),
        .digest_lane1 (digest.digest_lane1),
        .digest_lane2 (digest.digest_lane2),
        .digest_lane3 (digest.digest_lane3)
    );

endmodule

// ===== tb/sv/digest_checker.sv =====
module digest_checker
    import s256_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    s256_msg_if           message,
    s256_digest_if        digest,
    output int unsigned   failures,
    output int unsigned   digests_due,
    output int unsigned   words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        word_t      lane [LANES];
        logic [2:0] index;
        logic       done;
    } digest_word_t;

    word_t          chain_h [LANES][DIGEST_WORDS];
    word_t          block_buf [LANES][BLOCK_WORDS];
    int unsigned    block_fill;
    logic [30:0]    byte_count;
    digest_word_t   digest_words_due [$];

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void rearm_chain();
        foreach (chain_h[k, i])
            chain_h[k][i] = INIT_H[i];
        block_fill = 0;
        byte_count = '0;
    endfunction

    function automatic void compress_block();
        word_t w [ROUNDS];
        word_t v [DIGEST_WORDS];
        word_t s0, s1, t1, t2;
        for (int k = 0; k < LANES; k++)
        begin
            for (int t = 0; t < ROUNDS; t++)
            begin
                if (t < BLOCK_WORDS)
                    w[t] = block_buf[k][t];
                else
                begin
                    s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                    s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                    w[t] = s1 + w[t-7] + s0 + w[t-16];
                end
            end
            for (int i = 0; i < DIGEST_WORDS; i++)
                v[i] = chain_h[k][i];
            for (int t = 0; t < ROUNDS; t++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int i = DIGEST_WORDS - 1; i > 0; i--)
                    v[i] = v[i-1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_h[k][i] = chain_h[k][i] + v[i];
        end
    endfunction

    function automatic void absorb_row(input word_t row [LANES]);
        foreach (row[k])
            block_buf[k][block_fill] = row[k];
        if (block_fill == BLOCK_WORDS - 1)
        begin
            compress_block();
            block_fill = 0;
        end
        else
            block_fill++;
    endfunction

    function automatic void absorb_fill(input word_t x);
        word_t row [LANES];
        foreach (row[k])
            row[k] = x;
        absorb_row(row);
    endfunction

    function automatic void hash_transaction();
        word_t        row [LANES];
        int unsigned  nb;
        word_t        keep;
        word_t        mark;
        logic [63:0]  bit_len;
        digest_word_t dw;
        row = '{message.lane0_word, message.lane1_word,
                message.lane2_word, message.lane3_word};
        if (!message.message_end)
        begin
            absorb_row(row);
            byte_count = byte_count + 31'd4;
        end
        else
        begin
            nb = (message.valid_bytes > 3'd4) ? 4 : message.valid_bytes;
            byte_count = byte_count + 31'(nb);
            if (nb == 4)
            begin
                absorb_row(row);
                absorb_fill(PAD_MARK);
            end
            else
            begin
                keep = (nb == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * nb));
                mark = 32'h80 << (24 - 8 * nb);
                foreach (row[k])
                    row[k] = (row[k] & keep) | mark;
                absorb_row(row);
            end
            while (block_fill != BLOCK_WORDS - 2)
                absorb_fill('0);
            bit_len = {33'd0, byte_count} << 3;
            absorb_fill(bit_len[63:32]);
            absorb_fill(bit_len[31:0]);
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                foreach (dw.lane[k])
                    dw.lane[k] = chain_h[k][i];
                dw.index = 3'(i);
                dw.done = (i == DIGEST_WORDS - 1);
                digest_words_due.push_back(dw);
            end
            rearm_chain();
        end
    endfunction

    function automatic void check_digest_word();
        digest_word_t exp_w;
        word_t        got [LANES];
        got = '{digest.digest_lane0, digest.digest_lane1,
                digest.digest_lane2, digest.digest_lane3};
        if (digest_words_due.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected digest word %0d, nothing pending",
                     $time, digest.word_number);
        end
        else
        begin
            exp_w = digest_words_due.pop_front();
            words_checked++;
            foreach (got[k])
            begin
                if (got[k] !== exp_w.lane[k])
                begin
                    failures++;
                    $display("%0t: word %0d lane %0d expected %h actual %h",
                             $time, exp_w.index, k, exp_w.lane[k], got[k]);
                end
            end
            if (digest.word_number !== exp_w.index)
            begin
                failures++;
                $display("%0t: word_number expected %0d actual %0d",
                         $time, exp_w.index, digest.word_number);
            end
            if (digest.digest_done !== exp_w.done)
            begin
                failures++;
                $display("%0t: word %0d digest_done expected %b actual %b",
                         $time, exp_w.index, exp_w.done, digest.digest_done);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_chain();
            digest_words_due.delete();
            digests_due = 0;
        end
        else
        begin
            if (digest.valid && digest.ready)
                check_digest_word();
            if (message.valid && message.ready)
                hash_transaction();
            digests_due = digest_words_due.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import s256_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned sender_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned messages_sent = 0;
    int unsigned failures;
    int unsigned digests_due;
    int unsigned words_checked;

    s256_msg_if    msg ();
    s256_digest_if dig ();

    sha256_four_lane dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (msg),
        .digest  (dig)
    );

    digest_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .message       (msg),
        .digest        (dig),
        .failures      (failures),
        .digests_due   (digests_due),
        .words_checked (words_checked)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        dig.ready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic send_item(input word_t w [LANES], input logic [2:0] nb, input logic fin);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid       <= 1'b1;
        msg.lane0_word  <= w[0];
        msg.lane1_word  <= w[1];
        msg.lane2_word  <= w[2];
        msg.lane3_word  <= w[3];
        msg.valid_bytes <= nb;
        msg.message_end <= fin;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // non-final transactions sometimes carry a short count, which must be ignored
    task automatic send_message(input int unsigned n_words);
        word_t w [LANES];
        for (int unsigned i = 0; i < n_words; i++)
        begin
            foreach (w[k])
                w[k] = $urandom();
            if (i + 1 < n_words)
                send_item(w, ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
            else
                send_item(w, 3'($urandom_range(7)), 1'b1);
        end
        messages_sent++;
    endtask

    task automatic drain();
        msg.valid <= 1'b0;
        @(posedge clk);
        while (digests_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        word_t w [LANES];
        rst_n           <= 1'b0;
        msg.valid       <= 1'b0;
        msg.lane0_word  <= '0;
        msg.lane1_word  <= '0;
        msg.lane2_word  <= '0;
        msg.lane3_word  <= '0;
        msg.valid_bytes <= '0;
        msg.message_end <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-transaction messages: empty, one to four bytes, counts above four
        for (int nb = 0; nb < 8; nb++)
        begin
            if (nb % 2 == 0)
                w = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
            else
                w = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
            send_item(w, 3'(nb), 1'b1);
            messages_sent++;
        end

        // full block plus a separate padding block
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            foreach (w[k])
                w[k] = $urandom();
            send_item(w, (i == BLOCK_WORDS - 1) ? 3'd4 : 3'(i % 8), i == BLOCK_WORDS - 1);
        end
        messages_sent++;
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    sender_gap_pct = 65;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 65;
                end
                default:
                begin
                    sender_gap_pct = 18;
                    sink_stall_pct = 18;
                end
            endcase
            while (items_sent < 24 + 57 * (phase + 1))
                send_message(($urandom_range(7) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(1, 16));
            drain();
        end

        repeat (150) @(posedge clk);
        $display("Hashed %0d four-lane messages in %0d transactions (empty up to 40 words)",
                 messages_sent, items_sent);
        $display("under four stall mixes; %0d digest words compared.", words_checked);
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
